[sv/rlse_pkg.sv]
package rlse_pkg;

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_ALL   = 2'd1,
    REQ_PULL  = 2'd2
  } req_e;

  localparam logic [1:0] CH_GREEN = 2'd0;
  localparam logic [1:0] CH_RED   = 2'd1;

  localparam logic [2:0] ONE_CODE  = 3'd6;
  localparam logic [2:0] ZERO_CODE = 3'd4;
  localparam logic [2:0] GAP_CODE  = 3'd0;

  localparam logic [6:0] BRIGHT_MAX = 7'd100;

  // floor(x / 100) == (x * 5243) >> 19 for every x below 43699.
  localparam logic [12:0] DIV_MUL   = 13'd5243;
  localparam int unsigned DIV_SHIFT = 19;

  typedef struct packed {
    logic wr_single;
    logic load_px;
    logic wr_sweep;
    logic fill_zero;
    logic rd_en;
    logic mul_en;
    logic div_en;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

[sv/rlse_ram.sv]
module rlse_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/rlse_ctrl.sv]
module rlse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  rlse_pkg::status_t status_i,
  output rlse_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_FILL  = 6'b000100,
    S_MUL   = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.wr_sweep  = 1'b1;
        cmd_o.fill_zero = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.rd_en = 1'b1;
        if (in_valid_i) begin
          unique case (req_type_i)
            rlse_pkg::REQ_PIXEL: cmd_o.wr_single = 1'b1;
            rlse_pkg::REQ_ALL: begin
              cmd_o.load_px = 1'b1;
              state_d       = S_FILL;
            end
            rlse_pkg::REQ_PULL: state_d = S_MUL;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FILL: begin
        cmd_o.wr_sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_en = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

[sv/rlse_datapath.sv]
module rlse_datapath #(
  parameter int unsigned LED_COUNT   = 64,
  parameter int unsigned RESET_BYTES = 60
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rlse_pkg::cmd_t    cmd_i,
  output rlse_pkg::status_t status_o,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  input  logic [5:0]        led_index_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        spi_byte_o,
  output logic              frame_end_o
);

  localparam int unsigned AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned GW = (RESET_BYTES > 1) ? $clog2(RESET_BYTES) : 1;

  logic [6:0]    bright_q, bright_d;
  logic [AW-1:0] led_q, led_d;
  logic [1:0]    chan_q, chan_d;
  logic [2:0]    bit_q, bit_d;
  logic          gap_mode_q, gap_mode_d;
  logic [GW-1:0] gap_q, gap_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic          out_valid_q, out_valid_d;

  logic [23:0]   px_q;
  logic [14:0]   prod_q;
  logic [7:0]    val_q;
  logic [2:0]    spi_byte_q;
  logic          frame_end_q;

  logic [10:0]   idx_ext;
  logic          idx_ok;
  logic          led_last;
  logic          gap_last;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [23:0]   mem_wdata;
  logic [23:0]   mem_rdata;
  logic [7:0]    chan_raw;
  logic [27:0]   quot_full;
  logic          cur_bit;
  logic [2:0]    code;

  assign idx_ext  = {5'd0, led_index_i};
  assign idx_ok   = idx_ext < 11'(LED_COUNT);
  assign led_last = led_q == AW'(LED_COUNT - 1);
  assign gap_last = gap_q == GW'(RESET_BYTES - 1);

  assign status_o.sweep_last = sweep_q == AW'(LED_COUNT - 1);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign mem_we    = (cmd_i.wr_single && idx_ok) || cmd_i.wr_sweep;
  assign mem_waddr = cmd_i.wr_single ? idx_ext[AW-1:0] : sweep_q;

  always_comb begin
    if (cmd_i.wr_single) begin
      mem_wdata = {red_i, green_i, blue_i};
    end else if (cmd_i.fill_zero) begin
      mem_wdata = '0;
    end else begin
      mem_wdata = px_q;
    end
  end

  rlse_ram #(
    .WIDTH (24),
    .DEPTH (LED_COUNT)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (led_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    unique case (chan_q)
      rlse_pkg::CH_GREEN: chan_raw = mem_rdata[15:8];
      rlse_pkg::CH_RED:   chan_raw = mem_rdata[23:16];
      default:            chan_raw = mem_rdata[7:0];
    endcase
  end

  assign quot_full = 28'(prod_q) * 28'(rlse_pkg::DIV_MUL);
  assign cur_bit   = val_q[3'd7 - bit_q];

  always_comb begin
    if (gap_mode_q) begin
      code = rlse_pkg::GAP_CODE;
    end else if (cur_bit) begin
      code = rlse_pkg::ONE_CODE;
    end else begin
      code = rlse_pkg::ZERO_CODE;
    end
  end

  always_comb begin
    bright_d = bright_q;
    if (cfg_we_i) begin
      bright_d = (cfg_wdata_i > rlse_pkg::BRIGHT_MAX) ? rlse_pkg::BRIGHT_MAX : cfg_wdata_i;
    end
  end

  always_comb begin
    sweep_d = sweep_q;
    if (cmd_i.wr_sweep) begin
      sweep_d = status_o.sweep_last ? '0 : sweep_q + 1'b1;
    end
  end

  // The frame position is kept as LED, channel and bit counters plus a gap counter.
  always_comb begin
    led_d      = led_q;
    chan_d     = chan_q;
    bit_d      = bit_q;
    gap_mode_d = gap_mode_q;
    gap_d      = gap_q;
    if (cmd_i.emit) begin
      if (gap_mode_q) begin
        if (gap_last) begin
          gap_d      = '0;
          gap_mode_d = 1'b0;
        end else begin
          gap_d = gap_q + 1'b1;
        end
      end else begin
        bit_d = bit_q + 1'b1;
        if (bit_q == 3'd7) begin
          if (chan_q == 2'd2) begin
            chan_d = '0;
            if (led_last) begin
              led_d      = '0;
              gap_mode_d = 1'b1;
            end else begin
              led_d = led_q + 1'b1;
            end
          end else begin
            chan_d = chan_q + 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q    <= rlse_pkg::BRIGHT_MAX;
      led_q       <= '0;
      chan_q      <= '0;
      bit_q       <= '0;
      gap_mode_q  <= 1'b0;
      gap_q       <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bright_q    <= bright_d;
      led_q       <= led_d;
      chan_q      <= chan_d;
      bit_q       <= bit_d;
      gap_mode_q  <= gap_mode_d;
      gap_q       <= gap_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_px) begin
      px_q <= {red_i, green_i, blue_i};
    end
    if (cmd_i.mul_en) begin
      prod_q <= {7'd0, chan_raw} * {8'd0, bright_q};
    end
    if (cmd_i.div_en) begin
      val_q <= quot_full[rlse_pkg::DIV_SHIFT +: 8];
    end
    if (cmd_i.emit) begin
      spi_byte_q  <= code;
      frame_end_q <= gap_mode_q && gap_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign spi_byte_o  = spi_byte_q;
  assign frame_end_o = frame_end_q;

endmodule

[sv/rgb_led_spi_frame_encoder_top.sv]
// Frame encoder for a chain of addressable RGB LEDs. It keeps one 24-bit raw color per LED
// in a single-port-write, registered-read RAM and returns one SPI byte per pull transaction:
// G, R, B channels scaled by the brightness register, MSB first, 6 for a one bit and 4 for a
// zero bit, followed by RESET_BYTES zero bytes of which the last carries frame_end_o. The RAM
// is read at the edge that accepts a pull; the product with the brightness register is then
// registered in the multiply state, the divide by 100 through a reciprocal multiply in the
// divide state, and the bit select loads the result register in the emit state, which waits
// while the previous result has not yet been taken; no new transaction is accepted until the
// pull is through. A single pixel write is done at the edge that accepts it; a write to all
// pixels fills the RAM one entry per cycle. After reset the RAM is cleared one entry per cycle,
// so in_ready_o stays low until the clear is done.
module rgb_led_spi_frame_encoder_top #(
  parameter int unsigned LED_COUNT   = 64,
  parameter int unsigned RESET_BYTES = 60
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [5:0] led_index_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] spi_byte_o,
  output logic       frame_end_o
);

  rlse_pkg::cmd_t    cmd;
  rlse_pkg::status_t status;

  rlse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rlse_datapath #(
    .LED_COUNT   (LED_COUNT),
    .RESET_BYTES (RESET_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .led_index_i (led_index_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .spi_byte_o  (spi_byte_o),
    .frame_end_o (frame_end_o)
  );

endmodule

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEDS        = 64;
  localparam int unsigned GAP_BYTES   = 60;
  localparam int unsigned DATA_BYTES  = LEDS * 24;
  localparam int unsigned FRAME_BYTES = DATA_BYTES + GAP_BYTES;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int          PHASE_ITEMS = 264;

  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef struct packed {
    logic [2:0] code;
    logic       fend;
  } spi_beat_t;

  typedef struct packed {
    logic [1:0] req;
    logic [5:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       typed;
    logic [2:0] code;
    logic       fend;
  } dir_row_t;

  localparam int DIR_N = 23;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{rlse_pkg::REQ_PULL,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, rlse_pkg::ZERO_CODE, 1'b0},
    '{rlse_pkg::REQ_PULL,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, rlse_pkg::ZERO_CODE, 1'b0},
    '{REQ_NONE,            6'd63, 8'hff, 8'hff, 8'hff, 1'b0, rlse_pkg::GAP_CODE,  1'b0},
    '{rlse_pkg::REQ_PULL,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, rlse_pkg::ZERO_CODE, 1'b0},
    '{rlse_pkg::REQ_PIXEL, 6'd0,  8'hff, 8'hff, 8'hff, 1'b0, rlse_pkg::GAP_CODE,  1'b0},
    '{rlse_pkg::REQ_PULL,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, rlse_pkg::ONE_CODE,  1'b0},
    '{rlse_pkg::REQ_PIXEL, 6'd0,  8'h00, 8'hff, 8'h00, 1'b0, rlse_pkg::GAP_CODE,  1'b0},
    '{rlse_pkg::REQ_PULL,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, rlse_pkg::ONE_CODE,  1'b0},
    '{rlse_pkg::REQ_PIXEL, 6'd0,  8'hff, 8'h00, 8'hff, 1'b0, rlse_pkg::GAP_CODE,  1'b0},
    '{rlse_pkg::REQ_PULL,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, rlse_pkg::ZERO_CODE, 1'b0},
    '{rlse_pkg::REQ_PIXEL, 6'd63, 8'hff, 8'hff, 8'hff, 1'b0, rlse_pkg::GAP_CODE,  1'b0},
    '{rlse_pkg::REQ_PIXEL, 6'd1,  8'ha5, 8'h5a, 8'hc3, 1'b0, rlse_pkg::GAP_CODE,  1'b0},
    '{rlse_pkg::REQ_PULL,  6'd0,  8'h00, 8'h00, 8'h00, 1'b0, rlse_pkg::GAP_CODE,  1'b0},
    '{rlse_pkg::REQ_PULL,  6'd63, 8'hff, 8'hff, 8'hff, 1'b0, rlse_pkg::GAP_CODE,  1'b0},
    '{rlse_pkg::REQ_ALL,   6'd0,  8'h80, 8'h01, 8'h7f, 1'b0, rlse_pkg::GAP_CODE,  1'b0},
    '{rlse_pkg::REQ_PULL,  6'd0,  8'h00, 8'h00, 8'h00, 1'b0, rlse_pkg::GAP_CODE,  1'b0},
    '{rlse_pkg::REQ_PULL,  6'd0,  8'h00, 8'h00, 8'h00, 1'b0, rlse_pkg::GAP_CODE,  1'b0},
    '{rlse_pkg::REQ_ALL,   6'd0,  8'h00, 8'h00, 8'h00, 1'b0, rlse_pkg::GAP_CODE,  1'b0},
    '{rlse_pkg::REQ_PULL,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, rlse_pkg::ZERO_CODE, 1'b0},
    '{rlse_pkg::REQ_ALL,   6'd0,  8'hff, 8'hff, 8'hff, 1'b0, rlse_pkg::GAP_CODE,  1'b0},
    '{rlse_pkg::REQ_PULL,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, rlse_pkg::ONE_CODE,  1'b0},
    '{REQ_NONE,            6'd0,  8'h00, 8'h00, 8'h00, 1'b0, rlse_pkg::GAP_CODE,  1'b0},
    '{rlse_pkg::REQ_PULL,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, rlse_pkg::ONE_CODE,  1'b0}
  };

  localparam logic [6:0] BRIGHT_STEPS [7] = '{
    7'd0, 7'd127, 7'd1, 7'd50, 7'd101, 7'd0, 7'd100
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [6:0] cfg_wdata_i = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [1:0] req_type_i  = '0;
  logic [5:0] led_index_i = '0;
  logic [7:0] red_i       = '0;
  logic [7:0] green_i     = '0;
  logic [7:0] blue_i      = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] spi_byte_o;
  logic       frame_end_o;

  logic       row_typed = 1'b0;
  logic [2:0] row_code  = '0;
  logic       row_fend  = 1'b0;

  logic [23:0] shadow_px [LEDS];
  int unsigned shadow_pos;
  int unsigned shadow_bright;

  spi_beat_t spi_byte_q [$];
  int        mismatch_cnt = 0;
  bit        hold_req     = 1'b0;

  rgb_led_spi_frame_encoder_top #(
    .LED_COUNT  (LEDS),
    .RESET_BYTES(GAP_BYTES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .led_index_i(led_index_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .spi_byte_o (spi_byte_o),
    .frame_end_o(frame_end_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2ms;
    $display("[rgb_led_spi_frame_encoder_top] ERROR");
    $finish;
  end

  // Applies one accepted transaction to the shadow state; a pull yields the next frame byte.
  task automatic encode_request(input logic [1:0] req, input logic [5:0] idx,
                                input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, output bit got_byte,
                                output spi_beat_t beat);
    int unsigned led;
    int unsigned bitn;
    int unsigned raw;
    int unsigned val;
    logic [23:0] px;
    logic [1:0]  ch;
    got_byte = 1'b0;
    beat     = '0;
    case (req)
      rlse_pkg::REQ_PIXEL: begin
        if (idx < LEDS) shadow_px[idx] = {r, g, b};
      end
      rlse_pkg::REQ_ALL: begin
        for (int i = 0; i < LEDS; i++) shadow_px[i] = {r, g, b};
      end
      rlse_pkg::REQ_PULL: begin
        if (shadow_pos >= FRAME_BYTES) shadow_pos = 0;
        if (shadow_pos < DATA_BYTES) begin
          led  = shadow_pos / 24;
          bitn = shadow_pos % 24;
          px   = shadow_px[led];
          ch   = 2'(bitn / 8);
          if (ch == rlse_pkg::CH_GREEN) raw = px[15:8];
          else if (ch == rlse_pkg::CH_RED) raw = px[23:16];
          else raw = px[7:0];
          val       = (raw * shadow_bright) / int'(rlse_pkg::BRIGHT_MAX);
          beat.code = val[7 - (bitn % 8)] ? rlse_pkg::ONE_CODE : rlse_pkg::ZERO_CODE;
          beat.fend = 1'b0;
        end else begin
          beat.code = rlse_pkg::GAP_CODE;
          beat.fend = (shadow_pos == FRAME_BYTES - 1);
        end
        shadow_pos++;
        if (shadow_pos >= FRAME_BYTES) shadow_pos = 0;
        got_byte = 1'b1;
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    for (int i = 0; i < LEDS; i++) shadow_px[i] = '0;
    shadow_pos    = 0;
    shadow_bright = rlse_pkg::BRIGHT_MAX;
  end

  always @(posedge clk_i) begin
    bit        got;
    spi_beat_t beat;
    if (rst_ni && in_valid_i && in_ready_o) begin
      encode_request(req_type_i, led_index_i, red_i, green_i, blue_i, got, beat);
      if (got) begin
        if (row_typed) begin
          beat.code = row_code;
          beat.fend = row_fend;
        end
        spi_byte_q.push_back(beat);
      end
    end
  end

  always @(posedge clk_i) begin
    spi_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (spi_byte_q.size() == 0) begin
        $display("%0t: unexpected byte %0d frame_end %0d", $time, spi_byte_o, frame_end_o);
        mismatch_cnt++;
      end else begin
        want = spi_byte_q.pop_front();
        if (spi_byte_o !== want.code) begin
          $display("%0t: spi_byte expected %0d, got %0d", $time, want.code, spi_byte_o);
          mismatch_cnt++;
        end
        if (frame_end_o !== want.fend) begin
          $display("%0t: frame_end expected %0d, got %0d", $time, want.fend, frame_end_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // The receiver switches between stall patterns and, once asked, holds off for a long stretch.
  initial begin
    int  mode;
    int  len;
    int  tick;
    logic rdy;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(30, 250);
      repeat (len) begin
        @(posedge clk_i);
        tick++;
        if (hold_req) begin
          hold_req = 1'b0;
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end else begin
          case (mode)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            2:       rdy = (tick % 4 == 0);
            default: rdy = ($urandom_range(0, 7) != 0);
          endcase
          out_ready_i <= rdy;
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] req, input logic [5:0] idx,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic typed, input logic [2:0] code, input logic fend);
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    led_index_i <= idx;
    red_i       <= r;
    green_i     <= g;
    blue_i      <= b;
    row_typed   <= typed;
    row_code    <= code;
    row_fend    <= fend;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_gap(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (spi_byte_q.size() != 0) @(posedge clk_i);
    repeat (LEDS + 8) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_color();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [5:0] pick_index();
    case ($urandom_range(0, 5))
      0:       return 6'd0;
      1:       return 6'(LEDS - 1);
      default: return 6'($urandom_range(0, LEDS - 1));
    endcase
  endfunction

  task automatic run_phase(input int n_items, input bit gaps_on, input int hold_at);
    int         done_cnt;
    int         burst;
    int         sel;
    logic [1:0] req;
    done_cnt = 0;
    burst    = $urandom_range(1, 40);
    while (done_cnt < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 90) req = rlse_pkg::REQ_PULL;
      else if (sel < 96) req = rlse_pkg::REQ_PIXEL;
      else if (sel < 98) req = rlse_pkg::REQ_ALL;
      else req = REQ_NONE;
      send_item(req, pick_index(), pick_color(), pick_color(), pick_color(),
                1'b0, rlse_pkg::GAP_CODE, 1'b0);
      if (req != REQ_NONE) begin
        done_cnt++;
        if (done_cnt == hold_at) hold_req = 1'b1;
      end
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if (gaps_on) idle_gap($urandom_range(1, 8));
      end
    end
  endtask

  initial begin
    logic [6:0] level;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      send_item(DIR_ROWS[i].req, DIR_ROWS[i].idx, DIR_ROWS[i].red, DIR_ROWS[i].green,
                DIR_ROWS[i].blue, DIR_ROWS[i].typed, DIR_ROWS[i].code, DIR_ROWS[i].fend);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 5));
    end

    for (int p = 0; p < 7; p++) begin
      drain();
      level = (p == 5) ? 7'($urandom_range(2, 99)) : BRIGHT_STEPS[p];
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= level;
      @(posedge clk_i);
      cfg_we_i      <= 1'b0;
      shadow_bright = (level > rlse_pkg::BRIGHT_MAX) ? rlse_pkg::BRIGHT_MAX : level;
      run_phase(PHASE_ITEMS, p != 2, (p == 2) ? 20 : -1);
    end

    drain();
    if (mismatch_cnt == 0) begin
      $display("[rgb_led_spi_frame_encoder_top] OK");
    end else begin
      $display("[rgb_led_spi_frame_encoder_top] ERROR");
    end
    $finish;
  end

endmodule

[rgb_led_spi_frame_encoder_top.f]
sv/rlse_pkg.sv
sv/rlse_ram.sv
sv/rlse_ctrl.sv
sv/rlse_datapath.sv
sv/rgb_led_spi_frame_encoder_top.sv
tb/sv/tb.sv
